/* rtl/core/qsm3_pkg.sv */
// Shared sizes, types and sequencer states of the median-of-three quicksort engine.
package qsm3_pkg;

    localparam int DEPTH  = 64;
    localparam int DATA_W = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int STK_W  = 2 * IDX_W;

    typedef logic signed [DATA_W-1:0] elem_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_INIT,
        ST_RANGE,
        ST_POP,
        ST_P_RD0,
        ST_P_RD1,
        ST_P_RD2,
        ST_P_MED,
        ST_L_ISSUE,
        ST_L_CHK,
        ST_R_ISSUE,
        ST_R_CHK,
        ST_SWAP1,
        ST_SWAP2,
        ST_P_END,
        ST_P_PUSH,
        ST_O_ISSUE,
        ST_O_CAP
    } state_t;

endpackage

/* rtl/core/qsm3_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read.
module qsm3_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/quicksort_median_three_engine_unit.sv */
// Top level of the median-of-three quicksort engine: load, sort and stream out one set.
//
// The block collects signed elements, one per accepted request, into a 64-entry
// element memory; requests beyond that capacity are dropped and every result of
// the set then carries overflow_seen. A request marked last closes the set: the
// block stops taking requests, sorts the stored elements in place with quicksort
// (median-of-three pivot, Hoare partition, explicit range stack in a second
// memory, larger sub-range pushed) and then streams them out smallest first,
// with final_flag on the last one. The sort is bound by the single read port of
// the element memory. Each result is read from that memory and then captured,
// and the next read waits until the result side can take another result.
// As soon as the last result has been captured the block takes requests of the
// next set again, even while that result still waits on the result channel.
module quicksort_median_three_engine_unit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  qsm3_pkg::elem_t       s_element_value,
    input  logic                  s_last_element,
    output logic                  m_valid,
    input  logic                  m_ready,
    output qsm3_pkg::elem_t       m_sorted_value,
    output logic                  m_final_flag,
    output logic                  m_overflow_seen
);
    import qsm3_pkg::*;

    // Control state.
    state_t state_reg, state_next;
    cnt_t   count_reg, count_next;
    logic   ovf_reg, ovf_next;
    cnt_t   sp_reg, sp_next;
    idx_t   out_idx_reg, out_idx_next;
    logic   m_valid_reg, m_valid_next;

    // Datapath registers of the sort.
    idx_t   lo_reg, lo_next;
    idx_t   hi_reg, hi_next;
    idx_t   left_reg, left_next;
    idx_t   right_reg, right_next;
    idx_t   b_reg, b_next;
    elem_t  first_reg, first_next;
    elem_t  last_reg, last_next;
    elem_t  pivot_reg, pivot_next;
    elem_t  lval_reg, lval_next;
    elem_t  rval_reg, rval_next;

    // Output payload registers.
    elem_t  out_val_reg, out_val_next;
    logic   out_fin_reg, out_fin_next;
    logic   out_ovf_reg, out_ovf_next;

    // Memory ports.
    logic   el_we;
    idx_t   el_waddr;
    elem_t  el_wdata;
    idx_t   el_raddr;
    logic [DATA_W-1:0] el_rdata_raw;
    elem_t  el_rdata;
    logic   st_we;
    idx_t   st_waddr;
    logic [STK_W-1:0] st_wdata;
    idx_t   st_raddr;
    logic [STK_W-1:0] st_rdata;

    // Shared helper values.
    logic   s_accept;
    logic   room;
    cnt_t   range_size;
    idx_t   mid_idx;
    logic   l_adv;
    logic   r_adv;
    logic   out_final;
    logic   out_go;
    cnt_t   sp_clamp;
    cnt_t   lsize;
    cnt_t   rsize;
    logic   push_left;

    qsm3_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_elem_ram (
        .aclk  (aclk),
        .we    (el_we),
        .waddr (el_waddr),
        .wdata (el_wdata),
        .raddr (el_raddr),
        .rdata (el_rdata_raw)
    );

    qsm3_ram #(.WIDTH(STK_W), .DEPTH(DEPTH)) u_stack_ram (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    assign el_rdata = elem_t'(el_rdata_raw);

    assign s_ready  = (state_reg == ST_LOAD);
    assign s_accept = s_valid && s_ready;
    assign room     = (count_reg < cnt_t'(DEPTH));

    // Middle index of the current range: lo + size / 2.
    assign range_size = {1'b0, hi_reg} - {1'b0, lo_reg} + cnt_t'(1);
    assign mid_idx    = lo_reg + idx_t'(range_size >> 1);

    // Scan steps: keep moving while the element is strictly on the wrong side of the pivot.
    assign l_adv = (left_reg < hi_reg) && (el_rdata < pivot_reg);
    assign r_adv = (right_reg > lo_reg) && (pivot_reg < el_rdata);

    assign out_final = ({1'b0, out_idx_reg} + cnt_t'(1)) == count_reg;
    assign out_go    = !m_valid_reg || m_ready;

    // Range stack push: the pointer saturates at the top entry.
    assign sp_clamp  = (sp_reg >= cnt_t'(DEPTH)) ? cnt_t'(DEPTH - 1) : sp_reg;
    assign lsize     = {1'b0, b_reg} - {1'b0, lo_reg};
    assign rsize     = {1'b0, hi_reg} - {1'b0, b_reg} + cnt_t'(1);
    assign push_left = (lsize > rsize);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_accept && s_last_element) begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:  state_next = ST_RANGE;
            ST_RANGE: begin
                if (hi_reg > lo_reg) begin
                    state_next = ST_P_RD0;
                end else if (sp_reg != '0) begin
                    state_next = ST_POP;
                end else begin
                    state_next = ST_O_ISSUE;
                end
            end
            ST_POP:     state_next = ST_RANGE;
            ST_P_RD0:   state_next = ST_P_RD1;
            ST_P_RD1:   state_next = ST_P_RD2;
            ST_P_RD2:   state_next = ST_P_MED;
            ST_P_MED:   state_next = ST_L_ISSUE;
            ST_L_ISSUE: state_next = ST_L_CHK;
            ST_L_CHK: begin
                if (!l_adv) begin
                    state_next = ST_R_ISSUE;
                end
            end
            ST_R_ISSUE: state_next = ST_R_CHK;
            ST_R_CHK: begin
                if (!r_adv) begin
                    state_next = (left_reg >= right_reg) ? ST_P_END : ST_SWAP1;
                end
            end
            ST_SWAP1:  state_next = ST_SWAP2;
            ST_SWAP2:  state_next = ST_L_ISSUE;
            ST_P_END:  state_next = ST_P_PUSH;
            ST_P_PUSH: state_next = ST_RANGE;
            ST_O_ISSUE: begin
                if (out_go) begin
                    state_next = ST_O_CAP;
                end
            end
            ST_O_CAP: state_next = out_final ? ST_LOAD : ST_O_ISSUE;
            default:  state_next = ST_LOAD;
        endcase
    end

    // Memory controls.
    always_comb begin
        el_we    = 1'b0;
        el_waddr = count_reg[IDX_W-1:0];
        el_wdata = s_element_value;
        el_raddr = out_idx_reg;
        st_we    = 1'b0;
        st_waddr = sp_clamp[IDX_W-1:0];
        st_wdata = push_left ? {lo_reg, b_reg - idx_t'(1)} : {b_reg, hi_reg};
        st_raddr = idx_t'(sp_reg - cnt_t'(1));
        unique case (state_reg)
            ST_LOAD: begin
                el_we = s_accept && room;
            end
            ST_P_RD0:   el_raddr = lo_reg;
            ST_P_RD1:   el_raddr = hi_reg;
            ST_P_RD2:   el_raddr = mid_idx;
            ST_L_ISSUE: el_raddr = left_reg;
            ST_L_CHK:   el_raddr = left_reg + idx_t'(1);
            ST_R_ISSUE: el_raddr = right_reg;
            ST_R_CHK:   el_raddr = right_reg - idx_t'(1);
            ST_SWAP1: begin
                el_we    = 1'b1;
                el_waddr = left_reg;
                el_wdata = rval_reg;
            end
            ST_SWAP2: begin
                el_we    = 1'b1;
                el_waddr = right_reg;
                el_wdata = lval_reg;
            end
            ST_P_PUSH: st_we = 1'b1;
            default: begin
            end
        endcase
    end

    // Register next values.
    always_comb begin
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        sp_next      = sp_reg;
        out_idx_next = out_idx_reg;
        m_valid_next = m_valid_reg && !m_ready;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        b_next       = b_reg;
        first_next   = first_reg;
        last_next    = last_reg;
        pivot_next   = pivot_reg;
        lval_next    = lval_reg;
        rval_next    = rval_reg;
        out_val_next = out_val_reg;
        out_fin_next = out_fin_reg;
        out_ovf_next = out_ovf_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_accept) begin
                    if (room) begin
                        count_next = count_reg + cnt_t'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
            end
            ST_INIT: begin
                lo_next      = '0;
                hi_next      = idx_t'(count_reg - cnt_t'(1));
                sp_next      = '0;
                out_idx_next = '0;
            end
            ST_RANGE: begin
                if (!(hi_reg > lo_reg) && (sp_reg != '0)) begin
                    sp_next = sp_reg - cnt_t'(1);
                end
            end
            ST_POP: begin
                lo_next = st_rdata[STK_W-1:IDX_W];
                hi_next = st_rdata[IDX_W-1:0];
            end
            ST_P_RD1: first_next = el_rdata;
            ST_P_RD2: last_next  = el_rdata;
            ST_P_MED: begin
                // Median of first, last and the middle element now on the read port.
                if ((last_reg < first_reg) != (el_rdata < first_reg)) begin
                    pivot_next = first_reg;
                end else if ((first_reg < last_reg) != (el_rdata < last_reg)) begin
                    pivot_next = last_reg;
                end else begin
                    pivot_next = el_rdata;
                end
                left_next  = lo_reg;
                right_next = hi_reg;
            end
            ST_L_CHK: begin
                if (l_adv) begin
                    left_next = left_reg + idx_t'(1);
                end else begin
                    lval_next = el_rdata;
                end
            end
            ST_R_CHK: begin
                if (r_adv) begin
                    right_next = right_reg - idx_t'(1);
                end else begin
                    rval_next = el_rdata;
                end
            end
            ST_SWAP2: begin
                left_next  = left_reg + idx_t'(1);
                right_next = right_reg - idx_t'(1);
            end
            ST_P_END: begin
                // Split point is kept strictly inside the range.
                if (left_reg <= lo_reg) begin
                    b_next = lo_reg + idx_t'(1);
                end else if (left_reg > hi_reg) begin
                    b_next = hi_reg;
                end else begin
                    b_next = left_reg;
                end
            end
            ST_P_PUSH: begin
                sp_next = sp_clamp + cnt_t'(1);
                if (push_left) begin
                    lo_next = b_reg;
                end else begin
                    hi_next = b_reg - idx_t'(1);
                end
            end
            ST_O_CAP: begin
                out_val_next = el_rdata;
                out_fin_next = out_final;
                out_ovf_next = ovf_reg;
                m_valid_next = 1'b1;
                if (out_final) begin
                    count_next   = '0;
                    ovf_next     = 1'b0;
                    out_idx_next = '0;
                end else begin
                    out_idx_next = out_idx_reg + idx_t'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            sp_reg      <= '0;
            out_idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            sp_reg      <= sp_next;
            out_idx_reg <= out_idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        left_reg    <= left_next;
        right_reg   <= right_next;
        b_reg       <= b_next;
        first_reg   <= first_next;
        last_reg    <= last_next;
        pivot_reg   <= pivot_next;
        lval_reg    <= lval_next;
        rval_reg    <= rval_next;
        out_val_reg <= out_val_next;
        out_fin_reg <= out_fin_next;
        out_ovf_reg <= out_ovf_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_sorted_value  = out_val_reg;
    assign m_final_flag    = out_fin_reg;
    assign m_overflow_seen = out_ovf_reg;

    // The stored count never passes the memory depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= cnt_t'(DEPTH))
        else $error("element count beyond capacity");

    // The range stack pointer stays within the stack memory.
    a_sp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= cnt_t'(DEPTH))
        else $error("range stack pointer beyond capacity");

    // A left scan step never runs past the top of its range.
    a_left_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_L_CHK) |-> (left_reg <= hi_reg))
        else $error("left scan index past range");

    // A result becomes valid only right after a capture from the element memory.
    a_valid_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_O_CAP))
        else $error("result valid without capture");

endmodule
